>>> hdl/sdc_pkg.sv
package sdc_pkg;

  localparam int NSTAGE = 13;

  localparam logic signed [23:0] DAY_MIN  = -24'sd657434;
  localparam logic signed [23:0] DAY_MAX  = 24'sd2958465;
  localparam logic signed [24:0] Z_OFFSET = 25'sd693899;

  localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
  localparam logic [31:0] HALF_FRAC    = 32'h8000_0000;
  localparam logic [21:0] ERA_DAYS     = 22'd146097;
  localparam logic [15:0] QUAD_DAYS    = 16'd1461;
  localparam logic [16:0] HOUR_SECS    = 17'd3600;
  localparam logic [12:0] MIN_SECS     = 13'd60;

  typedef struct packed {
    logic        ok;
    logic [21:0] z;
    logic [48:0] p;
    logic [4:0]  era;
    logic [16:0] secs;
    logic        rnd;
    logic [4:0]  hh;
    logic [5:0]  wsum;
    logic [18:0] doe;
    logic [12:0] rh;
    logic [2:0]  wd;
    logic [1:0]  c;
    logic [15:0] doc;
    logic [5:0]  mi;
    logic [4:0]  q;
    logic [6:0]  ss;
    logic [11:0] doq;
    logic [1:0]  yq;
    logic [8:0]  doy;
    logic [8:0]  yoe;
    logic [3:0]  mp;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [8:0]  ycm;
    logic        jf;
    logic [8:0]  yd;
    logic [4:0]  dim;
    logic        roll;
  } stage_t;

  typedef struct packed {
    logic        date_valid;
    logic [13:0] cal_year;
    logic [3:0]  cal_month;
    logic [4:0]  cal_day;
    logic [4:0]  cal_hour;
    logic [5:0]  cal_minute;
    logic [5:0]  cal_second;
    logic [2:0]  week_day;
    logic [8:0]  year_day;
  } res_t;

  function automatic logic [18:0] cent_days(input logic [1:0] c);
    case (c)
      2'd0:    cent_days = 19'd0;
      2'd1:    cent_days = 19'd36524;
      2'd2:    cent_days = 19'd73048;
      default: cent_days = 19'd109572;
    endcase
  endfunction

  function automatic logic [10:0] year_off(input logic [1:0] yq);
    case (yq)
      2'd0:    year_off = 11'd0;
      2'd1:    year_off = 11'd365;
      2'd2:    year_off = 11'd730;
      default: year_off = 11'd1095;
    endcase
  endfunction

  function automatic logic [8:0] mar_start(input logic [3:0] mp);
    case (mp)
      4'd0:    mar_start = 9'd0;
      4'd1:    mar_start = 9'd31;
      4'd2:    mar_start = 9'd61;
      4'd3:    mar_start = 9'd92;
      4'd4:    mar_start = 9'd122;
      4'd5:    mar_start = 9'd153;
      4'd6:    mar_start = 9'd184;
      4'd7:    mar_start = 9'd214;
      4'd8:    mar_start = 9'd245;
      4'd9:    mar_start = 9'd275;
      4'd10:   mar_start = 9'd306;
      4'd11:   mar_start = 9'd337;
      default: mar_start = 9'd0;
    endcase
  endfunction

  function automatic logic [3:0] mar_month(input logic [8:0] doy);
    logic [3:0] cnt;
    cnt = '0;
    for (int k = 1; k < 12; k++) begin
      cnt = cnt + 4'(doy >= mar_start(4'(k)));
    end
    mar_month = cnt;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    case (m)
      4'd2:                         month_len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:      month_len = 5'd30;
      default:                      month_len = 5'd31;
    endcase
  endfunction

endpackage

>>> hdl/sdc_in_if.sv
interface sdc_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] day_number;
  logic        [31:0] day_fraction;

  modport source (output valid, day_number, day_fraction, input ready);
  modport sink (input valid, day_number, day_fraction, output ready);
endinterface

>>> hdl/sdc_out_if.sv
interface sdc_out_if;
  logic        valid;
  logic        ready;
  logic        date_valid;
  logic [13:0] cal_year;
  logic [3:0]  cal_month;
  logic [4:0]  cal_day;
  logic [4:0]  cal_hour;
  logic [5:0]  cal_minute;
  logic [5:0]  cal_second;
  logic [2:0]  week_day;
  logic [8:0]  year_day;

  modport source (
    output valid, date_valid, cal_year, cal_month, cal_day, cal_hour, cal_minute,
           cal_second, week_day, year_day,
    input  ready
  );
  modport sink (
    input  valid, date_valid, cal_year, cal_month, cal_day, cal_hour, cal_minute,
           cal_second, week_day, year_day,
    output ready
  );
endinterface

>>> hdl/sdc_core.sv
module sdc_core (
  input  logic                       clk,
  input  logic [sdc_pkg::NSTAGE-1:0] en,
  input  logic signed [23:0]         day_number,
  input  logic [31:0]                day_fraction,
  output sdc_pkg::res_t              res
);

  sdc_pkg::stage_t pipe      [sdc_pkg::NSTAGE];
  sdc_pkg::stage_t pipe_next [sdc_pkg::NSTAGE];

  logic signed [24:0] zs;
  logic [23:0]        w;
  logic [5:0]         wacc;
  logic [26:0]        prod27;
  logic [22:0]        prod23;
  logic [21:0]        tmp22;
  logic [16:0]        tmp17;
  logic [17:0]        prod18;
  logic [21:0]        prod22;
  logic [12:0]        tmp13;
  logic [15:0]        tmp16;
  logic [10:0]        tmp11;
  logic [8:0]         tmp9;
  logic [18:0]        tmp19;
  logic               leap;

  always_comb begin
    zs     = '0;
    w      = '0;
    wacc   = '0;
    prod27 = '0;
    prod23 = '0;
    tmp22  = '0;
    tmp17  = '0;
    prod18 = '0;
    prod22 = '0;
    tmp13  = '0;
    tmp16  = '0;
    tmp11  = '0;
    tmp9   = '0;
    tmp19  = '0;
    leap   = 1'b0;

    // range check, day offset, fraction times seconds per day
    pipe_next[0]    = '0;
    zs              = {day_number[23], day_number} + sdc_pkg::Z_OFFSET;
    pipe_next[0].ok = (day_number >= sdc_pkg::DAY_MIN) && (day_number <= sdc_pkg::DAY_MAX);
    pipe_next[0].z  = zs[21:0];
    pipe_next[0].p  = 49'(day_fraction) * 49'(sdc_pkg::SEC_PER_DAY);

    // estimate era and hour, fold weekday digits
    pipe_next[1]      = pipe[0];
    prod27            = 27'(pipe[0].z) * 27'd28;
    pipe_next[1].era  = prod27[26:22];
    pipe_next[1].secs = pipe[0].p[48:32];
    pipe_next[1].rnd  = pipe[0].p[31:0] > sdc_pkg::HALF_FRAC;
    prod23            = 23'(pipe[0].p[48:32]) * 23'd36;
    pipe_next[1].hh   = prod23[21:17];
    w                 = 24'(pipe[0].z) + 24'd3;
    for (int k = 0; k < 8; k++) begin
      wacc = wacc + 6'(w[3*k +: 3]);
    end
    pipe_next[1].wsum = wacc;

    // remainders after estimates
    pipe_next[2]      = pipe[1];
    tmp22             = pipe[1].z - 22'(pipe[1].era) * sdc_pkg::ERA_DAYS;
    pipe_next[2].doe  = tmp22[18:0];
    tmp17             = pipe[1].secs - 17'(pipe[1].hh) * sdc_pkg::HOUR_SECS;
    pipe_next[2].rh   = tmp17[12:0];
    pipe_next[2].wsum = 6'(4'(pipe[1].wsum[5:3]) + 4'(pipe[1].wsum[2:0]));

    // correct era and hour, finish weekday
    pipe_next[3] = pipe[2];
    if (pipe[2].doe >= 19'(sdc_pkg::ERA_DAYS)) begin
      pipe_next[3].era = pipe[2].era + 5'd1;
      pipe_next[3].doe = pipe[2].doe - 19'(sdc_pkg::ERA_DAYS);
    end
    if (pipe[2].rh >= 13'(sdc_pkg::HOUR_SECS)) begin
      pipe_next[3].hh = pipe[2].hh + 5'd1;
      pipe_next[3].rh = pipe[2].rh - 13'(sdc_pkg::HOUR_SECS);
    end
    if (pipe[2].wsum >= 6'd14) begin
      pipe_next[3].wd = 3'd0;
    end else if (pipe[2].wsum >= 6'd7) begin
      pipe_next[3].wd = 3'(pipe[2].wsum - 6'd7);
    end else begin
      pipe_next[3].wd = pipe[2].wsum[2:0];
    end

    // century of era, estimate minute
    pipe_next[4]     = pipe[3];
    pipe_next[4].c   = 2'(pipe[3].doe >= 19'd36524) + 2'(pipe[3].doe >= 19'd73048)
                     + 2'(pipe[3].doe >= 19'd109572);
    tmp19            = pipe[3].doe - sdc_pkg::cent_days(pipe_next[4].c);
    pipe_next[4].doc = tmp19[15:0];
    prod18           = 18'(pipe[3].rh[11:0]) * 18'd68;
    pipe_next[4].mi  = prod18[17:12];

    // estimate four-year block, second remainder
    pipe_next[5]    = pipe[4];
    prod22          = 22'(pipe[4].doc) * 22'd44;
    pipe_next[5].q  = prod22[20:16];
    tmp13           = pipe[4].rh - 13'(pipe[4].mi) * sdc_pkg::MIN_SECS;
    pipe_next[5].ss = tmp13[6:0];

    // block remainder, correct minute
    pipe_next[6]     = pipe[5];
    tmp16            = pipe[5].doc - 16'(pipe[5].q) * sdc_pkg::QUAD_DAYS;
    pipe_next[6].doq = tmp16[11:0];
    if (pipe[5].ss >= 7'(sdc_pkg::MIN_SECS)) begin
      pipe_next[6].mi = pipe[5].mi + 6'd1;
      pipe_next[6].ss = pipe[5].ss - 7'(sdc_pkg::MIN_SECS);
    end

    // correct block, round the second
    pipe_next[7]      = pipe[6];
    pipe_next[7].roll = 1'b0;
    if (pipe[6].doq >= 12'(sdc_pkg::QUAD_DAYS)) begin
      pipe_next[7].q   = pipe[6].q + 5'd1;
      pipe_next[7].doq = pipe[6].doq - 12'(sdc_pkg::QUAD_DAYS);
    end
    if (pipe[6].rnd) begin
      if (pipe[6].ss < 7'd59) begin
        pipe_next[7].ss = pipe[6].ss + 7'd1;
      end else begin
        pipe_next[7].ss = 7'd0;
        if (pipe[6].mi < 6'd59) begin
          pipe_next[7].mi = pipe[6].mi + 6'd1;
        end else begin
          pipe_next[7].mi = 6'd0;
          if (pipe[6].hh < 5'd23) begin
            pipe_next[7].hh = pipe[6].hh + 5'd1;
          end else begin
            pipe_next[7].hh   = 5'd0;
            pipe_next[7].roll = 1'b1;
          end
        end
      end
    end

    // year within block, day within year
    pipe_next[8]     = pipe[7];
    pipe_next[8].yq  = 2'(pipe[7].doq >= 12'd365) + 2'(pipe[7].doq >= 12'd730)
                     + 2'(pipe[7].doq >= 12'd1095);
    tmp11            = pipe[7].doq[10:0] - sdc_pkg::year_off(pipe_next[8].yq);
    pipe_next[8].doy = tmp11[8:0];

    // year of era, month from March
    pipe_next[9]     = pipe[8];
    pipe_next[9].yoe = 9'(pipe[8].c) * 9'd100 + 9'(pipe[8].q) * 9'd4 + 9'(pipe[8].yq);
    pipe_next[9].mp  = sdc_pkg::mar_month(pipe[8].doy);

    // calendar month, day and year
    pipe_next[10]     = pipe[9];
    tmp9              = pipe[9].doy - sdc_pkg::mar_start(pipe[9].mp) + 9'd1;
    pipe_next[10].day = tmp9[4:0];
    pipe_next[10].jf  = pipe[9].mp >= 4'd10;
    if (pipe[9].mp >= 4'd10) begin
      pipe_next[10].month = pipe[9].mp - 4'd9;
    end else begin
      pipe_next[10].month = pipe[9].mp + 4'd3;
    end
    pipe_next[10].ycm  = pipe[9].yoe + 9'(pipe_next[10].jf);
    pipe_next[10].year = 14'(pipe[9].era) * 14'd400 + 14'(pipe[9].yoe)
                       + 14'(pipe_next[10].jf);

    // leap year, day of year, month length
    pipe_next[11] = pipe[10];
    leap = (pipe[10].ycm[1:0] == 2'd0) && (pipe[10].ycm != 9'd100)
        && (pipe[10].ycm != 9'd200) && (pipe[10].ycm != 9'd300);
    if (pipe[10].jf) begin
      pipe_next[11].yd = pipe[10].doy - 9'd305;
    end else begin
      pipe_next[11].yd = pipe[10].doy + 9'd60 + 9'(leap);
    end
    pipe_next[11].dim = sdc_pkg::month_len(pipe[10].month, leap);

    // carry rounding into the date, clear out of range
    pipe_next[12] = pipe[11];
    if (pipe[11].roll) begin
      if (pipe[11].day == pipe[11].dim) begin
        pipe_next[12].day = 5'd1;
        if (pipe[11].month == 4'd12) begin
          pipe_next[12].month = 4'd1;
          pipe_next[12].year  = pipe[11].year + 14'd1;
        end else begin
          pipe_next[12].month = pipe[11].month + 4'd1;
        end
      end else begin
        pipe_next[12].day = pipe[11].day + 5'd1;
      end
    end
    if (!pipe[11].ok) begin
      pipe_next[12].year  = '0;
      pipe_next[12].month = '0;
      pipe_next[12].day   = '0;
      pipe_next[12].hh    = '0;
      pipe_next[12].mi    = '0;
      pipe_next[12].ss    = '0;
      pipe_next[12].wd    = '0;
      pipe_next[12].yd    = '0;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < sdc_pkg::NSTAGE; k++) begin
      if (en[k]) begin
        pipe[k] <= pipe_next[k];
      end
    end
  end

  assign res.date_valid = pipe[sdc_pkg::NSTAGE-1].ok;
  assign res.cal_year   = pipe[sdc_pkg::NSTAGE-1].year;
  assign res.cal_month  = pipe[sdc_pkg::NSTAGE-1].month;
  assign res.cal_day    = pipe[sdc_pkg::NSTAGE-1].day;
  assign res.cal_hour   = pipe[sdc_pkg::NSTAGE-1].hh;
  assign res.cal_minute = pipe[sdc_pkg::NSTAGE-1].mi;
  assign res.cal_second = pipe[sdc_pkg::NSTAGE-1].ss[5:0];
  assign res.week_day   = pipe[sdc_pkg::NSTAGE-1].wd;
  assign res.year_day   = pipe[sdc_pkg::NSTAGE-1].yd;

endmodule

>>> hdl/serial_date_to_calendar.sv
// One beat per cycle unless an output stall backs up to the input; thirteen
// register stages hold the divide-by-constant steps (reciprocal multiply or its
// correction), table lookups, range check, time rounding and its date carry.
// A stalled output stage holds; earlier stages keep filling empty slots.
// Reset (rst, synchronous) clears the stage valid bits only; no other state.
module serial_date_to_calendar (
  input  logic      clk,
  input  logic      rst,
  sdc_in_if.sink    stamp,
  sdc_out_if.source calendar
);

  logic [sdc_pkg::NSTAGE-1:0] vld;
  logic [sdc_pkg::NSTAGE-1:0] en;
  sdc_pkg::res_t              res;

  always_comb begin
    en[sdc_pkg::NSTAGE-1] = !vld[sdc_pkg::NSTAGE-1] || calendar.ready;
    for (int k = sdc_pkg::NSTAGE - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= stamp.valid;
      end
      for (int k = 1; k < sdc_pkg::NSTAGE; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  sdc_core u_core (
    .clk          (clk),
    .en           (en),
    .day_number   (stamp.day_number),
    .day_fraction (stamp.day_fraction),
    .res          (res)
  );

  assign stamp.ready         = en[0];
  assign calendar.valid      = vld[sdc_pkg::NSTAGE-1];
  assign calendar.date_valid = res.date_valid;
  assign calendar.cal_year   = res.cal_year;
  assign calendar.cal_month  = res.cal_month;
  assign calendar.cal_day    = res.cal_day;
  assign calendar.cal_hour   = res.cal_hour;
  assign calendar.cal_minute = res.cal_minute;
  assign calendar.cal_second = res.cal_second;
  assign calendar.week_day   = res.week_day;
  assign calendar.year_day   = res.year_day;

endmodule

>>> bench/sdc_calendar_checker.sv
`timescale 1ns / 100ps

module sdc_calendar_checker (
  input  logic clk,
  input  logic rst,
  sdc_in_if    stamp,
  sdc_out_if   calendar,
  output int   mismatches,
  output int   outstanding
);

  localparam int unsigned JD_BASE = 32'd657434 + 32'd1757585;

  localparam int unsigned CUM_DAYS [13] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                            304, 334};
  localparam int unsigned MONTH_DAYS [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31,
                                              30, 31};

  sdc_pkg::res_t expected_dates [$];
  sdc_pkg::res_t want;
  int            errs = 0;

  function automatic bit leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    if (m == 2 && leap_year(y))
      return 29;
    return MONTH_DAYS[(m >= 1 && m <= 12) ? m : 1];
  endfunction

  function automatic sdc_pkg::res_t to_calendar(input logic signed [23:0] day,
                                                input logic [31:0] frac);
    int              sday;
    int unsigned     jd, l, n, i, j, y, m, dd, wd, yd;
    int unsigned     secs, rem, hh, mi, ss;
    longint unsigned prod;
    sdc_pkg::res_t   r;
    r = '0;
    sday = day;
    if (sday < int'(sdc_pkg::DAY_MIN) || sday > int'(sdc_pkg::DAY_MAX))
      return r;

    jd = int'(sday) + JD_BASE;
    l  = jd + 68569;
    n  = (l * 4) / 146097;
    l  = l - (n * 146097 + 3) / 4;
    i  = (4000 * (l + 1)) / 1461001;
    l  = l + 31 - (i * 1461) / 4;
    j  = (l * 80) / 2447;
    dd = l - (j * 2447) / 80;
    l  = j / 11;
    m  = j + 2 - 12 * l;
    y  = 100 * (n - 49) + i + l;

    wd = ((((sday - 1) % 7) + 7) % 7);
    yd = CUM_DAYS[m <= 12 ? m : 0] + dd;
    if (m > 2 && leap_year(y))
      yd = yd + 1;

    prod = longint'(frac) * 64'd86400;
    secs = prod[63:32];
    rem  = prod[31:0];
    hh   = secs / 3600;
    mi   = (secs % 3600) / 60;
    ss   = secs % 60;

    if (rem > sdc_pkg::HALF_FRAC) begin
      if (ss < 59) begin
        ss++;
      end else begin
        ss = 0;
        if (mi < 59) begin
          mi++;
        end else begin
          mi = 0;
          if (hh < 23) begin
            hh++;
          end else begin
            hh = 0;
            dd++;
            if (dd > month_length(y, m)) begin
              dd = 1;
              m++;
              if (m > 12) begin
                m = 1;
                y++;
              end
            end
          end
        end
      end
    end

    r.date_valid = 1'b1;
    r.cal_year   = y[13:0];
    r.cal_month  = m[3:0];
    r.cal_day    = dd[4:0];
    r.cal_hour   = hh[4:0];
    r.cal_minute = mi[5:0];
    r.cal_second = ss[5:0];
    r.week_day   = wd[2:0];
    r.year_day   = yd[8:0];
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned got_val);
    if (exp_val != got_val) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, got_val);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (stamp.valid && stamp.ready)
        expected_dates.push_back(to_calendar(stamp.day_number, stamp.day_fraction));
      if (calendar.valid && calendar.ready) begin
        if (expected_dates.size() == 0) begin
          $display("%0t: result beat expected none, got year %0d month %0d day %0d", $time,
                   calendar.cal_year, calendar.cal_month, calendar.cal_day);
          errs++;
        end else begin
          want = expected_dates.pop_front();
          check_field("date_valid", 32'(want.date_valid), 32'(calendar.date_valid));
          check_field("cal_year",   32'(want.cal_year),   32'(calendar.cal_year));
          check_field("cal_month",  32'(want.cal_month),  32'(calendar.cal_month));
          check_field("cal_day",    32'(want.cal_day),    32'(calendar.cal_day));
          check_field("cal_hour",   32'(want.cal_hour),   32'(calendar.cal_hour));
          check_field("cal_minute", 32'(want.cal_minute), 32'(calendar.cal_minute));
          check_field("cal_second", 32'(want.cal_second), 32'(calendar.cal_second));
          check_field("week_day",   32'(want.week_day),   32'(calendar.week_day));
          check_field("year_day",   32'(want.year_day),   32'(calendar.year_day));
        end
      end
    end
    mismatches <= errs;
    outstanding <= expected_dates.size();
  end

endmodule

>>> bench/tb_serial_date_to_calendar.sv
`timescale 1ns / 100ps

module tb_serial_date_to_calendar;

  localparam int N_RANDOM = 1900;
  localparam int DAY_SPAN = 3615899;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatches;
  int   outstanding;

  sdc_in_if  stamp ();
  sdc_out_if calendar ();

  serial_date_to_calendar uut (
    .clk      (clk),
    .rst      (rst),
    .stamp    (stamp),
    .calendar (calendar)
  );

  sdc_calendar_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .stamp       (stamp),
    .calendar    (calendar),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_stamp(input logic signed [23:0] day, input logic [31:0] frac);
    stamp.valid        <= 1'b1;
    stamp.day_number   <= day;
    stamp.day_fraction <= frac;
    @(posedge clk);
    while (!stamp.ready) @(posedge clk);
  endtask

  // fraction within a step of the half-second point of second-of-day s
  function automatic logic [31:0] near_round(input int unsigned s);
    longint unsigned t;
    t = ((longint'(s) << 32) + 64'h8000_0000) / 64'd86400;
    return 32'(t + $urandom_range(0, 2) - 1);
  endfunction

  function automatic logic signed [23:0] pick_day();
    int sel, base;
    sel = $urandom_range(0, 99);
    if (sel < 12)
      return 24'($urandom);
    if (sel < 22) begin
      base = $urandom_range(0, 1) ? int'(sdc_pkg::DAY_MIN) : int'(sdc_pkg::DAY_MAX);
      return 24'(base + int'($urandom_range(0, 4)) - 2);
    end
    return 24'(int'(sdc_pkg::DAY_MIN) + int'($urandom_range(0, DAY_SPAN)));
  endfunction

  function automatic logic [31:0] pick_fraction();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40)
      return $urandom;
    if (sel < 75)
      return near_round($urandom_range(0, 86399));
    if (sel < 92)
      return near_round(60 * $urandom_range(0, 1439) + 59);
    return near_round(86399);
  endfunction

  initial begin
    calendar.ready = 1'b0;
    forever begin
      @(posedge clk);
      case ($urandom_range(0, 3))
        0: repeat ($urandom_range(20, 200)) begin
             calendar.ready <= 1'b1;
             @(posedge clk);
           end
        1: repeat ($urandom_range(20, 200)) begin
             calendar.ready <= ($urandom_range(0, 9) < 7);
             @(posedge clk);
           end
        2: repeat ($urandom_range(5, 50)) begin
             calendar.ready <= 1'b1;
             @(posedge clk);
             calendar.ready <= 1'b0;
             repeat ($urandom_range(1, 4)) @(posedge clk);
           end
        default: repeat ($urandom_range(20, 200)) begin
             calendar.ready <= ($urandom_range(0, 9) < 3);
             @(posedge clk);
           end
      endcase
    end
  end

  initial begin
    int burst;
    stamp.valid        = 1'b0;
    stamp.day_number   = '0;
    stamp.day_fraction = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_stamp(24'sd0, 32'h0000_0000);
    send_stamp(24'sd1, 32'h8000_0000);
    send_stamp(-24'sd1, 32'h4000_0000);
    send_stamp(sdc_pkg::DAY_MIN, 32'h0000_0000);
    send_stamp(sdc_pkg::DAY_MIN, 32'hFFFF_FFFF);
    send_stamp(sdc_pkg::DAY_MAX, 32'hFFFF_FFFF);
    send_stamp(sdc_pkg::DAY_MAX, 32'h0000_0000);
    send_stamp(sdc_pkg::DAY_MIN - 24'sd1, 32'hFFFF_FFFF);
    send_stamp(sdc_pkg::DAY_MAX + 24'sd1, 32'h0000_0000);
    send_stamp(24'sh80_0000, 32'hFFFF_FFFF);
    send_stamp(24'sd8388607, 32'h1234_5678);
    send_stamp(24'sd60, 32'hFFFF_FFFF);
    send_stamp(24'sd36584, 32'hFFFF_FFFF);
    send_stamp(24'sd36585, 32'hFFFF_FFFF);
    send_stamp(24'sd36525, 32'hFFFF_FFFF);
    send_stamp(24'sd100, 32'h0100_0000);
    send_stamp(24'sd100, 32'h0100_0001);
    send_stamp(-24'sd36524, 32'h00FF_FFFF);
    send_stamp(24'sd2958100, 32'hAAAA_AAAA);
    send_stamp(-24'sd657000, 32'h5555_5555);
    stamp.valid <= 1'b0;
    repeat (3) @(posedge clk);

    for (int sent = 0; sent < N_RANDOM; ) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && sent < N_RANDOM; b++) begin
        send_stamp(pick_day(), pick_fraction());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        stamp.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    stamp.valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (sdc_pkg::NSTAGE + 10) @(posedge clk);
    if (mismatches == 0)
      $display("tb_serial_date_to_calendar passed");
    else
      $display("tb_serial_date_to_calendar failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_serial_date_to_calendar failed");
    $finish;
  end

endmodule
